// ===== sv/command_frame_receiver_replier_macros.svh =====
// Assertion helpers shared by the command frame receiver and replier.
`ifndef COMMAND_FRAME_RECEIVER_REPLIER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_REPLIER_MACROS_SVH

// Check a same-cycle implication, masked while in reset.
`define CFCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, masked while in reset.
`define CFCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cfcr_pkg.sv =====
package cfcr_pkg;

  localparam logic [7:0] HDR0      = 8'h5E;
  localparam logic [7:0] HDR1      = 8'h0C;
  localparam logic [3:0] FRAME_LEN = 4'd10;
  localparam logic [3:0] LAST_IDX  = 4'd9;
  localparam logic [3:0] SUM_HI    = 4'd8;

  typedef enum logic [2:0] {
    EV_ACK    = 3'd0,
    EV_WAIT   = 3'd1,
    EV_STOP   = 3'd2,
    EV_TASK   = 3'd3,
    EV_REPORT = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_STOP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_NODE_ID     = 3'd0,
    CFG_WAIT_CODE   = 3'd1,
    CFG_STOP_CODE   = 3'd2,
    CFG_TASK_CODE   = 3'd3,
    CFG_REPLY_CODE  = 3'd4,
    CFG_REPORT_CODE = 3'd5
  } cfg_idx_e;

  // One outgoing packet: bytes two to seven plus the fields shown on every byte
  typedef struct packed {
    logic [7:0]  node;
    logic [7:0]  cmd;
    logic [31:0] data;
    event_e      ev;
    logic [15:0] target_x;
    logic [15:0] target_y;
  } packet_t;

endpackage

// ===== sv/cfcr_front.sv =====
module cfcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_start_i,
  input  logic [15:0]       pos_x_i,
  input  logic [15:0]       pos_y_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              push_o,
  output cfcr_pkg::packet_t desc_o
);

  logic [7:0] node_id_q, wait_code_q, stop_code_q, task_code_q, reply_code_q, report_code_q;

  logic [3:0]  byte_count_q, byte_count_d;
  logic [15:0] sum_q, sum_d;
  logic        hok_q, hok_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  payload_q [4];
  logic [7:0]  payload_d [4];
  logic [7:0]  sum_high_q, sum_high_d;
  cfcr_pkg::mode_e mode_q, mode_d;
  logic [15:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;

  logic [3:0]  cnt_eff;
  logic [15:0] sum_eff;
  logic        hok_eff;
  cfcr_pkg::event_e ev;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q     <= 8'd1;
      wait_code_q   <= 8'd1;
      stop_code_q   <= 8'd2;
      task_code_q   <= 8'd3;
      reply_code_q  <= 8'd4;
      report_code_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfcr_pkg::CFG_NODE_ID:     node_id_q     <= cfg_data_i;
        cfcr_pkg::CFG_WAIT_CODE:   wait_code_q   <= cfg_data_i;
        cfcr_pkg::CFG_STOP_CODE:   stop_code_q   <= cfg_data_i;
        cfcr_pkg::CFG_TASK_CODE:   task_code_q   <= cfg_data_i;
        cfcr_pkg::CFG_REPLY_CODE:  reply_code_q  <= cfg_data_i;
        cfcr_pkg::CFG_REPORT_CODE: report_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse received bytes and decide which packet to queue
  always_comb begin
    byte_count_d = byte_count_q;
    sum_d        = sum_q;
    hok_d        = hok_q;
    cmd_d        = cmd_q;
    payload_d    = payload_q;
    sum_high_d   = sum_high_q;
    mode_d       = mode_q;
    tgt_x_d      = tgt_x_q;
    tgt_y_d      = tgt_y_q;
    push_o       = 1'b0;
    ev           = cfcr_pkg::EV_ACK;
    desc_o       = '0;
    cnt_eff      = frame_start_i ? 4'd0 : byte_count_q;
    sum_eff      = frame_start_i ? 16'd0 : sum_q;
    hok_eff      = frame_start_i ? 1'b1 : hok_q;

    if (accept_i) begin
      if (operation_i) begin
        // Position report from the current position
        push_o          = 1'b1;
        desc_o.node     = node_id_q;
        desc_o.cmd      = (mode_q == cfcr_pkg::MODE_WAIT) ? wait_code_q : report_code_q;
        desc_o.data     = {pos_x_i, pos_y_i};
        desc_o.ev       = cfcr_pkg::EV_REPORT;
        desc_o.target_x = tgt_x_q;
        desc_o.target_y = tgt_y_q;
      end else begin
        if (frame_start_i) begin
          byte_count_d = 4'd0;
          sum_d        = 16'd0;
          hok_d        = 1'b1;
        end
        if (cnt_eff < cfcr_pkg::FRAME_LEN) begin
          byte_count_d = cnt_eff + 4'd1;
          if (cnt_eff < cfcr_pkg::SUM_HI) begin
            sum_d = sum_eff + {8'd0, data_byte_i};
            case (cnt_eff)
              4'd0:    hok_d = (data_byte_i == cfcr_pkg::HDR0);
              4'd1:    hok_d = hok_eff && (data_byte_i == cfcr_pkg::HDR1);
              4'd2:    hok_d = hok_eff && (data_byte_i == node_id_q);
              4'd3:    cmd_d = data_byte_i;
              default: payload_d[cnt_eff[1:0]] = data_byte_i;
            endcase
          end else if (cnt_eff == cfcr_pkg::SUM_HI) begin
            sum_high_d = data_byte_i;
          end else if (hok_eff && ({sum_high_q, data_byte_i} == sum_eff)) begin
            // Act on a good frame, first matching code wins
            if (cmd_q == wait_code_q) begin
              mode_d = cfcr_pkg::MODE_WAIT;
              ev     = cfcr_pkg::EV_WAIT;
            end else if (cmd_q == stop_code_q) begin
              mode_d = cfcr_pkg::MODE_STOP;
              ev     = cfcr_pkg::EV_STOP;
            end else if (cmd_q == task_code_q) begin
              tgt_x_d = {payload_q[0], payload_q[1]};
              tgt_y_d = {payload_q[2], payload_q[3]};
              ev      = cfcr_pkg::EV_TASK;
            end
            push_o          = 1'b1;
            desc_o.node     = node_id_q;
            desc_o.cmd      = reply_code_q;
            desc_o.data     = 32'd0;
            desc_o.ev       = ev;
            desc_o.target_x = tgt_x_d;
            desc_o.target_y = tgt_y_d;
          end
        end
      end
    end
  end

  // Hold receive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= cfcr_pkg::FRAME_LEN;
      sum_q        <= 16'd0;
      hok_q        <= 1'b0;
      cmd_q        <= 8'd0;
      payload_q    <= '{default: 8'd0};
      sum_high_q   <= 8'd0;
      mode_q       <= cfcr_pkg::MODE_NONE;
      tgt_x_q      <= 16'd0;
      tgt_y_q      <= 16'd0;
    end else begin
      byte_count_q <= byte_count_d;
      sum_q        <= sum_d;
      hok_q        <= hok_d;
      cmd_q        <= cmd_d;
      payload_q    <= payload_d;
      sum_high_q   <= sum_high_d;
      mode_q       <= mode_d;
      tgt_x_q      <= tgt_x_d;
      tgt_y_q      <= tgt_y_d;
    end
  end

endmodule

// ===== sv/cfcr_queue.sv =====
`include "command_frame_receiver_replier_macros.svh"

module cfcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfcr_pkg::packet_t desc_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cfcr_pkg::packet_t desc_o
);

  cfcr_pkg::packet_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign desc_o  = slot_q[rd_ptr_q];

  // Store pushed packets
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `CFCR_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "push into full queue")
  `CFCR_ASSERT_IMPL(a_no_pop_empty, pop_i, valid_o, "pop from empty queue")
  `CFCR_ASSERT_IMPL(a_count_range, 1'b1, count_q != 2'd3, "queue count out of range")

endmodule

// ===== sv/cfcr_back.sv =====
`include "command_frame_receiver_replier_macros.svh"

module cfcr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cfcr_pkg::packet_t q_desc_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        tx_byte_o,
  output logic              tx_last_o,
  output logic [2:0]        event_res_o,
  output logic [15:0]       target_x_o,
  output logic [15:0]       target_y_o
);

  cfcr_pkg::packet_t cur_q, cur_d;
  logic        busy_q, busy_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] sum_q, sum_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [2:0]  ev_q, ev_d;
  logic [15:0] tx_q, tx_d, ty_q, ty_d;

  logic       advance, last_now;
  logic [7:0] cur_byte;

  assign advance  = !out_valid_q || !out_stall_i;
  assign last_now = busy_q && (idx_q == cfcr_pkg::LAST_IDX);
  assign q_pop_o  = q_valid_i && (!busy_q || (advance && last_now));

  // Select the byte at the current position
  always_comb begin
    unique case (idx_q)
      4'd0:    cur_byte = cfcr_pkg::HDR0;
      4'd1:    cur_byte = cfcr_pkg::HDR1;
      4'd2:    cur_byte = cur_q.node;
      4'd3:    cur_byte = cur_q.cmd;
      4'd4:    cur_byte = cur_q.data[31:24];
      4'd5:    cur_byte = cur_q.data[23:16];
      4'd6:    cur_byte = cur_q.data[15:8];
      4'd7:    cur_byte = cur_q.data[7:0];
      4'd8:    cur_byte = sum_q[15:8];
      4'd9:    cur_byte = sum_q[7:0];
      default: cur_byte = 8'd0;
    endcase
  end

  // Serialize the current packet into the output register
  always_comb begin
    cur_d       = cur_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    ev_d        = ev_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    if (advance) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        byte_d = cur_byte;
        last_d = last_now;
        ev_d   = cur_q.ev;
        tx_d   = cur_q.target_x;
        ty_d   = cur_q.target_y;
        idx_d  = idx_q + 4'd1;
        if (idx_q < cfcr_pkg::SUM_HI) sum_d = sum_q + {8'd0, cur_byte};
        if (last_now) busy_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_d  = q_desc_i;
      busy_d = 1'b1;
      idx_d  = 4'd0;
      sum_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sum_q  <= sum_d;
    byte_q <= byte_d;
    last_q <= last_d;
    ev_q   <= ev_d;
    tx_q   <= tx_d;
    ty_q   <= ty_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = byte_q;
  assign tx_last_o   = last_q;
  assign event_res_o = ev_q;
  assign target_x_o  = tx_q;
  assign target_y_o  = ty_q;

  `CFCR_ASSERT_IMPL(a_idx_range, busy_q, idx_q < cfcr_pkg::FRAME_LEN, "byte index past frame")
  `CFCR_ASSERT_NEXT(a_last_frees, advance && last_now && !q_valid_i, !busy_q,
                    "serializer still busy after last byte")

endmodule

// ===== sv/command_frame_receiver_replier.sv =====
// Command frame receiver and replier. Received bytes (operation 0) are taken one per cycle
// unless the input is stalled, and parsed into 10-byte frames (5E 0C, node id, command,
// four payload bytes, 16-bit big-endian sum); a good frame queues a 10-byte
// acknowledgement, a report request (operation 1) queues a 10-byte position frame. The
// transmit side sends one byte per cycle while out_stall_i is low, packets back to back.
// A two-entry packet queue separates the parser from the serializer; the input stalls only
// while that queue is full. Configuration writes are accepted every cycle (cfg_ready_o is
// always high).
module command_frame_receiver_replier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [2:0]  event_res_o,
  output logic [15:0] target_x_o,
  output logic [15:0] target_y_o
);

  logic              q_full, q_valid, q_push, q_pop;
  cfcr_pkg::packet_t push_desc, pop_desc;

  assign in_stall_o  = q_full;
  assign cfg_ready_o = 1'b1;

  cfcr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_valid_i && !q_full),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_o        (q_push),
    .desc_o        (push_desc)
  );

  cfcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .desc_o  (pop_desc)
  );

  cfcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (pop_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .tx_last_o   (tx_last_o),
    .event_res_o (event_res_o),
    .target_x_o  (target_x_o),
    .target_y_o  (target_y_o)
  );

endmodule

// ===== dv/tb_command_frame_receiver_replier.sv =====
`timescale 1ns / 1ps

module tb_command_frame_receiver_replier;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 12;
  localparam int NUM_REGS     = int'(cfcr_pkg::CFG_REPORT_CODE) + 1;

  // One transmitted byte with the fields shown alongside it
  typedef struct {
    logic [7:0]        data;
    logic              last;
    cfcr_pkg::event_e  ev;
    logic [15:0]       tx;
    logic [15:0]       ty;
  } tx_beat_t;

  // Directed stimulus row; n and ev are only compared where chk is set
  typedef struct {
    logic              op;
    logic [7:0]        b;
    logic              st;
    logic [15:0]       px;
    logic [15:0]       py;
    bit                chk;
    int                n;
    cfcr_pkg::event_e  ev;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        operation_i   = 1'b0;
  logic [7:0]  data_byte_i   = '0;
  logic        frame_start_i = 1'b0;
  logic [15:0] pos_x_i       = '0;
  logic [15:0] pos_y_i       = '0;
  logic        cfg_valid_i   = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        cfg_ready_o;
  logic        out_valid_o;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic [2:0]  event_res_o;
  logic [15:0] target_x_o;
  logic [15:0] target_y_o;

  command_frame_receiver_replier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_byte_o     (tx_byte_o),
    .tx_last_o     (tx_last_o),
    .event_res_o   (event_res_o),
    .target_x_o    (target_x_o),
    .target_y_o    (target_y_o)
  );

  // Register shadow and receive state of the predictor
  logic [7:0]  cfg_shadow [NUM_REGS] = '{8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
  logic [3:0]  frame_pos     = cfcr_pkg::FRAME_LEN;
  logic [15:0] frame_sum     = '0;
  logic        frame_hdr_ok  = 1'b0;
  logic [7:0]  frame_cmd     = '0;
  logic [7:0]  frame_payload [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [7:0]  frame_sum_hi  = '0;
  cfcr_pkg::mode_e node_mode_q = cfcr_pkg::MODE_NONE;
  logic [15:0] target_x_q    = '0;
  logic [15:0] target_y_q    = '0;

  tx_beat_t          tx_expect [$];
  int                pred_bytes;
  cfcr_pkg::event_e  pred_ev;
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          packets_expected = 0;
  int          beats_seen = 0;
  int          settings_run = 0;
  dir_row_t    dir_rows [27];

  always #2 clk_i = ~clk_i;

  // Print one line per mismatch and count it
  task automatic flag_error(input string what, input logic [15:0] got,
                            input logic [15:0] want);
    errors++;
    $display("ERROR t=%0t %s: got 0x%h expected 0x%h", $time, what, got, want);
  endtask

  // Append the ten bytes of one packet, closing with its 16-bit sum
  task automatic queue_packet(input logic [7:0] body [8], input cfcr_pkg::event_e ev);
    logic [15:0] sum;
    tx_beat_t    beat;
    sum = '0;
    foreach (body[k]) sum = sum + {8'd0, body[k]};
    for (int k = 0; k < int'(cfcr_pkg::FRAME_LEN); k++) begin
      if (k < int'(cfcr_pkg::SUM_HI)) begin
        beat.data = body[k];
      end else if (k == int'(cfcr_pkg::SUM_HI)) begin
        beat.data = sum[15:8];
      end else begin
        beat.data = sum[7:0];
      end
      beat.last = (k == int'(cfcr_pkg::LAST_IDX));
      beat.ev   = ev;
      beat.tx   = target_x_q;
      beat.ty   = target_y_q;
      tx_expect.push_back(beat);
    end
    packets_expected++;
  endtask

  // Advance the frame parser by one accepted item and queue any reply
  task automatic predict_reply(input logic op, input logic [7:0] b, input logic st,
                               input logic [15:0] px, input logic [15:0] py);
    logic [7:0]  body [8];
    logic [7:0]  cmd;
    logic [15:0] check;
    logic [3:0]  pos;
    pred_bytes = 0;
    pred_ev    = cfcr_pkg::EV_ACK;
    // Position report leaves the receive state alone
    if (op) begin
      cmd  = (node_mode_q == cfcr_pkg::MODE_WAIT) ? cfg_shadow[cfcr_pkg::CFG_WAIT_CODE]
                                                  : cfg_shadow[cfcr_pkg::CFG_REPORT_CODE];
      body = '{cfcr_pkg::HDR0, cfcr_pkg::HDR1, cfg_shadow[cfcr_pkg::CFG_NODE_ID], cmd,
               px[15:8], px[7:0], py[15:8], py[7:0]};
      pred_ev = cfcr_pkg::EV_REPORT;
      queue_packet(body, pred_ev);
      pred_bytes = int'(cfcr_pkg::FRAME_LEN);
      return;
    end
    if (st) begin
      frame_pos    = '0;
      frame_sum    = '0;
      frame_hdr_ok = 1'b1;
    end
    // Drop bytes past the end of a frame or before any start
    if (frame_pos >= cfcr_pkg::FRAME_LEN) return;
    pos       = frame_pos;
    frame_pos = frame_pos + 4'd1;
    if (pos < cfcr_pkg::SUM_HI) begin
      frame_sum = frame_sum + {8'd0, b};
      case (pos)
        4'd0:    frame_hdr_ok = (b == cfcr_pkg::HDR0);
        4'd1:    frame_hdr_ok = frame_hdr_ok && (b == cfcr_pkg::HDR1);
        4'd2:    frame_hdr_ok = frame_hdr_ok && (b == cfg_shadow[cfcr_pkg::CFG_NODE_ID]);
        4'd3:    frame_cmd = b;
        default: frame_payload[pos[1:0]] = b;
      endcase
      return;
    end
    if (pos == cfcr_pkg::SUM_HI) begin
      frame_sum_hi = b;
      return;
    end
    check = {frame_sum_hi, b};
    if (!frame_hdr_ok || check != frame_sum) return;
    // Commands match in the order wait, stop, task
    if (frame_cmd == cfg_shadow[cfcr_pkg::CFG_WAIT_CODE]) begin
      node_mode_q = cfcr_pkg::MODE_WAIT;
      pred_ev     = cfcr_pkg::EV_WAIT;
    end else if (frame_cmd == cfg_shadow[cfcr_pkg::CFG_STOP_CODE]) begin
      node_mode_q = cfcr_pkg::MODE_STOP;
      pred_ev     = cfcr_pkg::EV_STOP;
    end else if (frame_cmd == cfg_shadow[cfcr_pkg::CFG_TASK_CODE]) begin
      target_x_q = {frame_payload[0], frame_payload[1]};
      target_y_q = {frame_payload[2], frame_payload[3]};
      pred_ev    = cfcr_pkg::EV_TASK;
    end
    body = '{cfcr_pkg::HDR0, cfcr_pkg::HDR1, cfg_shadow[cfcr_pkg::CFG_NODE_ID],
             cfg_shadow[cfcr_pkg::CFG_REPLY_CODE], 8'h00, 8'h00, 8'h00, 8'h00};
    queue_packet(body, pred_ev);
    pred_bytes = int'(cfcr_pkg::FRAME_LEN);
  endtask

  // Drive one input item, idling at random first, and predict it on transfer
  task automatic send_item(input logic op, input logic [7:0] b, input logic st,
                           input logic [15:0] px, input logic [15:0] py);
    bit taken;
    while (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    data_byte_i   <= b;
    frame_start_i <= st;
    pos_x_i       <= px;
    pos_y_i       <= py;
    do begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      if (taken) predict_reply(op, b, st, px, py);
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // Hold input idle until every reply is out, then let the parser drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tx_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers back to back
  task automatic load_config(input logic [7:0] v [NUM_REGS]);
    cfcr_pkg::cfg_idx_e idx;
    bit                 taken;
    idx = idx.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= v[idx];
      do begin
        @(negedge clk_i);
        taken = (cfg_ready_o === 1'b1);
        if (taken) cfg_shadow[idx] = v[idx];
        @(posedge clk_i);
      end while (!taken);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // Random frame: mostly well formed, sometimes flawed, cut short,
  // interleaved with reports or followed by excess bytes
  task automatic send_frame();
    logic [7:0]  fb [cfcr_pkg::FRAME_LEN];
    logic [15:0] fsum;
    int          cut;
    int          flaw;
    case ($urandom_range(0, 4))
      0:       fb[3] = cfg_shadow[cfcr_pkg::CFG_WAIT_CODE];
      1:       fb[3] = cfg_shadow[cfcr_pkg::CFG_STOP_CODE];
      2:       fb[3] = cfg_shadow[cfcr_pkg::CFG_TASK_CODE];
      3:       fb[3] = cfg_shadow[cfcr_pkg::CFG_REPORT_CODE];
      default: fb[3] = 8'($urandom);
    endcase
    fb[0] = cfcr_pkg::HDR0;
    fb[1] = cfcr_pkg::HDR1;
    fb[2] = cfg_shadow[cfcr_pkg::CFG_NODE_ID];
    for (int k = 4; k < int'(cfcr_pkg::SUM_HI); k++) fb[k] = 8'($urandom);
    fsum = '0;
    for (int k = 0; k < int'(cfcr_pkg::SUM_HI); k++) fsum = fsum + {8'd0, fb[k]};
    fb[cfcr_pkg::SUM_HI]   = fsum[15:8];
    fb[cfcr_pkg::LAST_IDX] = fsum[7:0];
    flaw = $urandom_range(0, 11);
    if (flaw < 4) begin
      fb[(flaw == 3) ? int'($urandom_range(int'(cfcr_pkg::SUM_HI), int'(cfcr_pkg::LAST_IDX)))
                     : flaw] ^= 8'(1 << $urandom_range(0, 7));
    end
    cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, int'(cfcr_pkg::LAST_IDX)))
                                      : int'(cfcr_pkg::FRAME_LEN);
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(1'b1, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      end
      send_item(1'b0, fb[k], (k == 0), 16'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(1'b0, 8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Compare each transmitted byte against the oldest expectation
  always @(negedge clk_i) begin : tx_check
    tx_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (tx_expect.size() == 0) begin
        flag_error("unexpected transfer, tx_byte", 16'(tx_byte_o), '0);
      end else begin
        want = tx_expect.pop_front();
        if (tx_byte_o !== want.data) flag_error("tx_byte", 16'(tx_byte_o), 16'(want.data));
        if (tx_last_o !== want.last) flag_error("tx_last", 16'(tx_last_o), 16'(want.last));
        if (event_res_o !== want.ev) flag_error("event_res", 16'(event_res_o), 16'(want.ev));
        if (target_x_o !== want.tx) flag_error("target_x", target_x_o, want.tx);
        if (target_y_o !== want.ty) flag_error("target_y", target_y_o, want.ty);
        beats_seen++;
      end
    end
  end

  // Stall the transmit side at random except in calm stretches
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 25);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d bytes still expected",
               cycle_count, tx_expect.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main
    int          mark;
    logic [7:0]  regs [NUM_REGS];
    dir_rows = '{
      // report straight after reset; start flag and byte ignored
      '{1'b1, 8'hA5, 1'b1, 16'h0000, 16'h0000, 1'b1, 10, cfcr_pkg::EV_REPORT},
      '{1'b1, 8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 10, cfcr_pkg::EV_REPORT},
      // stray byte before any frame start
      '{1'b0, 8'hFF, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 0, cfcr_pkg::EV_ACK},
      // frame abandoned after two bytes
      '{1'b0, 8'h5E, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h0C, 1'b0, 16'h1234, 16'h5678, 1'b0, 0, cfcr_pkg::EV_ACK},
      // restart: task to the far corner
      '{1'b0, 8'h5E, 1'b1, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h0C, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h01, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h03, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h04, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h6A, 1'b0, 16'h0000, 16'h0000, 1'b1, 10, cfcr_pkg::EV_TASK},
      // excess byte after a complete frame
      '{1'b0, 8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 0, cfcr_pkg::EV_ACK},
      // wait command
      '{1'b0, 8'h5E, 1'b1, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h0C, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h01, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h01, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0, cfcr_pkg::EV_ACK},
      '{1'b0, 8'h6C, 1'b0, 16'h0000, 16'h0000, 1'b1, 10, cfcr_pkg::EV_WAIT},
      // report while waiting carries the wait code
      '{1'b1, 8'hFF, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 10, cfcr_pkg::EV_REPORT}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, typed results cross-checked where given
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].op, dir_rows[r].b, dir_rows[r].st,
                dir_rows[r].px, dir_rows[r].py);
      if (dir_rows[r].chk) begin
        if (pred_bytes != dir_rows[r].n)
          flag_error($sformatf("directed row %0d reply bytes", r), 16'(pred_bytes),
                     16'(dir_rows[r].n));
        if (dir_rows[r].n != 0 && pred_ev != dir_rows[r].ev)
          flag_error($sformatf("directed row %0d event", r), 16'(pred_ev),
                     16'(dir_rows[r].ev));
      end
    end

    // Random phases under several register settings, extremes among them
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: foreach (regs[k]) regs[k] = 8'($urandom);
        1: foreach (regs[k]) regs[k] = 8'h00;
        2: foreach (regs[k]) regs[k] = 8'hFF;
        default: begin
          foreach (regs[k]) regs[k] = 8'($urandom);
          regs[cfcr_pkg::CFG_TASK_CODE] = regs[cfcr_pkg::CFG_STOP_CODE];
        end
      endcase
      load_config(regs);
      calm = (phase == 1);
      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                    16'($urandom), 16'($urandom));
        end else begin
          send_frame();
        end
      end
      calm = 1'b0;
    end

    settle();
    if (tx_expect.size() != 0) flag_error("bytes never sent", 16'(tx_expect.size()), '0);
    $display("Sent %0d input items over %0d register settings", items_sent, settings_run + 1);
    $display("Checked %0d transmit bytes from %0d predicted packets, %0d mismatches",
             beats_seen, packets_expected, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
